// ===== design/bpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared constants, codes and controller/datapath signal groups for the
// LSB-first bit packer/unpacker.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int BUFFER_BYTES_DEF   = 4096;
  localparam int MAX_FIELD_BITS_DEF = 32;
  localparam int VALUE_W            = 32;
  localparam int COUNT_W            = 6;
  localparam int BYTE_W             = 8;
  localparam int BIT_IDX_W          = 3;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_UNDERRUN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PUSH,
    ST_PULL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic push_step;
    logic pull_step;
    logic flag_full;
    logic flag_under;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic is_pull;
    logic push_fits;
    logic pull_avail;
    logic zero_count;
    logic last_step;
  } flags_t;

endpackage

// ===== design/bpu_in_if.sv =====
// ----------------------------------------------------------------------------
// bpu_in_if
// Request channel: push or pull command with value and bit count.
// ----------------------------------------------------------------------------
interface bpu_in_if;
  logic                         valid;
  logic                         ready;
  bpu_pkg::cmd_t                cmd;
  logic [bpu_pkg::VALUE_W-1:0]  write_value;
  logic [bpu_pkg::COUNT_W-1:0]  bit_count;

  modport source (output valid, cmd, write_value, bit_count, input ready);
  modport sink   (input valid, cmd, write_value, bit_count, output ready);
endinterface

// ===== design/bpu_out_if.sv =====
// ----------------------------------------------------------------------------
// bpu_out_if
// Response channel: pulled value and status code.
// ----------------------------------------------------------------------------
interface bpu_out_if;
  logic                         valid;
  logic                         ready;
  logic [bpu_pkg::VALUE_W-1:0]  read_value;
  bpu_pkg::status_t             status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

// ===== design/lsb_first_bit_packer_unpacker.sv =====
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_unpacker
// LSB-first bit stream writer/reader over a byte RAM with write and read
// bit pointers.
// ----------------------------------------------------------------------------
// An item of n bits starting at bit offset o within its byte touches
// k = ceil((o + n) / 8) bytes and passes from acceptance through ST_CHECK,
// k byte steps in ST_PUSH or ST_PULL and then ST_FINISH, where its result
// is loaded into the output register; zero-count and flagged items go from
// ST_CHECK straight to ST_FINISH. A new item is taken once the previous
// result sits in the output register, and ST_FINISH waits while the output
// is held off. The byte count k is set by the byte RAM, which moves one byte
// per cycle. Bytes are written through as bits arrive and reads never pass
// the write pointer, so the RAM needs no clearing pass after reset.
module lsb_first_bit_packer_unpacker #(
  parameter int BUFFER_BYTES   = bpu_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = bpu_pkg::MAX_FIELD_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  bpu_in_if.sink  req,
  bpu_out_if.source rsp
);

  bpu_pkg::ctrl_t  ctrl;
  bpu_pkg::flags_t flags;

  bpu_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .flags     (flags),
    .ctrl      (ctrl)
  );

  bpu_datapath #(
    .BUFFER_BYTES   (BUFFER_BYTES),
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .flags       (flags),
    .cmd         (req.cmd),
    .write_value (req.write_value),
    .bit_count   (req.bit_count),
    .read_value  (rsp.read_value),
    .status      (rsp.status)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while an item is in progress");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == bpu_pkg::STATUS_FULL |-> rsp.read_value == '0)
    else $error("dropped push returned nonzero value");

  a_under_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == bpu_pkg::STATUS_UNDERRUN |-> rsp.read_value == '0)
    else $error("failed pull returned nonzero value");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.capture, ctrl.push_step, ctrl.pull_step, ctrl.load_out}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== design/bpu_ram.sv =====
// ----------------------------------------------------------------------------
// bpu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/bpu_datapath.sv =====
// ----------------------------------------------------------------------------
// bpu_datapath
// Bit pointers, byte RAM, partial-byte register and field shifters; moves
// one byte of a field per step.
// ----------------------------------------------------------------------------
module bpu_datapath #(
  parameter int BUFFER_BYTES   = bpu_pkg::BUFFER_BYTES_DEF,
  parameter int MAX_FIELD_BITS = bpu_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bpu_pkg::ctrl_t               ctrl,
  output bpu_pkg::flags_t              flags,
  input  bpu_pkg::cmd_t                cmd,
  input  logic [bpu_pkg::VALUE_W-1:0]  write_value,
  input  logic [bpu_pkg::COUNT_W-1:0]  bit_count,
  output logic [bpu_pkg::VALUE_W-1:0]  read_value,
  output bpu_pkg::status_t             status
);

  localparam int CAP_BITS = BUFFER_BYTES * bpu_pkg::BYTE_W;
  localparam int PTR_W    = $clog2(CAP_BITS + 1);
  localparam int AW       = $clog2(BUFFER_BYTES);
  localparam int LIM      = (MAX_FIELD_BITS > 64) ? 64 : MAX_FIELD_BITS;
  localparam int CNT_W    = $clog2(LIM + 1);
  localparam int BW       = bpu_pkg::BYTE_W;
  localparam int BIW      = bpu_pkg::BIT_IDX_W;

  logic [PTR_W-1:0]             wpos, rpos;
  logic [BW-1:0]                pbyte;
  bpu_pkg::cmd_t                cmd_r;
  logic [bpu_pkg::VALUE_W-1:0]  val;
  logic [bpu_pkg::VALUE_W-1:0]  acc;
  logic [CNT_W-1:0]             rem, acc_cnt, n_clamp;
  bpu_pkg::status_t             status_r;

  logic [PTR_W-1:0]             pos, rpos_next;
  logic [BIW-1:0]               off;
  logic [BIW:0]                 room, take;
  logic [BW-1:0]                tmask, new_byte, rd_data, pull_bits;
  logic [AW-1:0]                raddr;

  always_comb begin
    if (int'(bit_count) > LIM) begin
      n_clamp = CNT_W'(LIM);
    end else begin
      n_clamp = CNT_W'(bit_count);
    end
  end

  always_comb begin
    pos   = (cmd_r == bpu_pkg::CMD_PULL) ? rpos : wpos;
    off   = pos[BIW-1:0];
    room  = (BIW+1)'(BW) - {1'b0, off};
    take  = (rem < CNT_W'(room)) ? (BIW+1)'(rem) : room;
    tmask = BW'(((BW+1)'(1) << take) - (BW+1)'(1));
    new_byte  = pbyte | BW'((val[BW-1:0] & tmask) << off);
    pull_bits = (rd_data >> off) & tmask;
    rpos_next = rpos + PTR_W'(take);
    raddr     = ctrl.pull_step ? rpos_next[BIW +: AW] : rpos[BIW +: AW];
  end

  always_comb begin
    flags.is_pull    = (cmd_r == bpu_pkg::CMD_PULL);
    flags.push_fits  = ({1'b0, wpos} + (PTR_W+1)'(rem)) <= (PTR_W+1)'(CAP_BITS);
    flags.pull_avail = ({1'b0, rpos} + (PTR_W+1)'(rem)) <= {1'b0, wpos};
    flags.zero_count = (rem == '0);
    flags.last_step  = (rem == CNT_W'(take));
  end

  bpu_ram #(
    .WIDTH (BW),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.push_step),
    .waddr (wpos[BIW +: AW]),
    .wdata (new_byte),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // pointers and partial byte; bit 0 of byte 0 is the zero header flag
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos  <= PTR_W'(1);
      rpos  <= PTR_W'(1);
      pbyte <= '0;
    end else begin
      if (ctrl.push_step) begin
        wpos <= wpos + PTR_W'(take);
        if (({1'b0, off} + take) == (BIW+1)'(BW)) begin
          pbyte <= '0;
        end else begin
          pbyte <= new_byte;
        end
      end
      if (ctrl.pull_step) begin
        rpos <= rpos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r    <= cmd;
      val      <= write_value;
      rem      <= n_clamp;
      acc      <= '0;
      acc_cnt  <= '0;
      status_r <= bpu_pkg::STATUS_OK;
    end else begin
      if (ctrl.push_step) begin
        val <= val >> take;
        rem <= rem - CNT_W'(take);
      end
      if (ctrl.pull_step) begin
        acc     <= acc | (bpu_pkg::VALUE_W'(pull_bits) << acc_cnt);
        acc_cnt <= acc_cnt + CNT_W'(take);
        rem     <= rem - CNT_W'(take);
      end
      if (ctrl.flag_full) begin
        status_r <= bpu_pkg::STATUS_FULL;
      end
      if (ctrl.flag_under) begin
        status_r <= bpu_pkg::STATUS_UNDERRUN;
      end
    end
    if (ctrl.load_out) begin
      read_value <= acc;
      status     <= status_r;
    end
  end

endmodule

// ===== design/bpu_controller.sv =====
// ----------------------------------------------------------------------------
// bpu_controller
// Sequencer: accept, bounds check, byte steps, hand-off to output register.
// ----------------------------------------------------------------------------
module bpu_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bpu_pkg::flags_t  flags,
  output bpu_pkg::ctrl_t   ctrl
);

  bpu_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpu_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    ctrl           = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      bpu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next   = bpu_pkg::ST_CHECK;
        end
      end
      bpu_pkg::ST_CHECK: begin
        if (flags.is_pull) begin
          if (!flags.pull_avail) begin
            ctrl.flag_under = 1'b1;
            state_next      = bpu_pkg::ST_FINISH;
          end else if (flags.zero_count) begin
            state_next = bpu_pkg::ST_FINISH;
          end else begin
            state_next = bpu_pkg::ST_PULL;
          end
        end else begin
          if (!flags.push_fits) begin
            ctrl.flag_full = 1'b1;
            state_next     = bpu_pkg::ST_FINISH;
          end else if (flags.zero_count) begin
            state_next = bpu_pkg::ST_FINISH;
          end else begin
            state_next = bpu_pkg::ST_PUSH;
          end
        end
      end
      bpu_pkg::ST_PUSH: begin
        ctrl.push_step = 1'b1;
        if (flags.last_step) begin
          state_next = bpu_pkg::ST_FINISH;
        end
      end
      bpu_pkg::ST_PULL: begin
        ctrl.pull_step = 1'b1;
        if (flags.last_step) begin
          state_next = bpu_pkg::ST_FINISH;
        end
      end
      bpu_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          ctrl.load_out  = 1'b1;
          out_valid_next = 1'b1;
          state_next     = bpu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bpu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
